@@ src/assert_macros.svh @@
// Assertion macros shared by the checker modules of the table block.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property with reset disable
`define AST_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle implies consequent in the same cycle
`define AST_SAME(label, ante, cons, msg) `AST_CLK(label, (ante) |-> (cons), msg)

// Antecedent this cycle implies consequent on the next cycle
`define AST_NEXT(label, ante, cons, msg) `AST_CLK(label, (ante) |=> (cons), msg)

`endif

@@ src/atids_pkg.sv @@
// Package for the ordered table block: field widths, status and kind codes,
// and the sequencer state type. No dependencies.
`default_nettype none

package atids_pkg;

	localparam int DATA_W = 32;
	localparam int KIND_W = 2;
	localparam int SLOT_W = 7;
	localparam int STAT_W = 2;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int TOT_W  = 38;

	// request kinds; any other code is a search
	localparam logic [KIND_W-1:0] KIND_INS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_DEL_RD,
		ST_DEL_SUB,
		ST_DEL,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ src/atids_mem.sv @@
// Entry storage: one write port and one read port with registered read data.
// Depends on atids_pkg for the data width.
`default_nettype none

module atids_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                         clk,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [atids_pkg::DATA_W-1:0] wr_data,
	input  wire logic [AW-1:0]                rd_addr,
	output logic      [atids_pkg::DATA_W-1:0] rd_data
);

	logic [atids_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [atids_pkg::DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ src/array_table_insert_delete_search_top.sv @@
// Ordered table with insert, delete and linear search; top level.
// Depends on atids_pkg and atids_mem.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid/in_ready, kind, slot, item_data  | request in
//  out     | out_valid/out_ready, status, found,       | result out
//          | found_index, entry_count, smallest,       |
//          | largest, total                            |
//
// Each request runs through the one entry memory: an insert moves (count - slot)
// entries, a delete moves (count - slot - 1), then a scan over count entries
// computes min, max and the search hit.
// Reset clears the count and the sum; entries need no clearing pass.
// in_ready is high only while idle; a finished result waits in the output
// register and the next request is taken while it waits.
`default_nettype none

module array_table_insert_delete_search_top #(
	parameter int DEPTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [atids_pkg::KIND_W-1:0] kind,
	input  wire logic        [atids_pkg::SLOT_W-1:0] slot,
	input  wire logic signed [atids_pkg::DATA_W-1:0] item_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic             [atids_pkg::STAT_W-1:0] status,
	output logic                                     found,
	output logic             [atids_pkg::IDX_W-1:0]  found_index,
	output logic             [atids_pkg::CNT_W-1:0]  entry_count,
	output logic signed      [atids_pkg::DATA_W-1:0] smallest,
	output logic signed      [atids_pkg::DATA_W-1:0] largest,
	output logic signed      [atids_pkg::TOT_W-1:0]  total
);

	localparam int DW = atids_pkg::DATA_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (CW > atids_pkg::SLOT_W) ? CW : atids_pkg::SLOT_W;
	localparam int IW = (AW > atids_pkg::IDX_W) ? AW : atids_pkg::IDX_W;
	localparam int TW = (DW + AW > atids_pkg::TOT_W) ? DW + AW : atids_pkg::TOT_W;

	atids_pkg::state_t state_q, next_state;

	// control registers
	logic [CW-1:0]        occ_q;
	logic signed [TW-1:0] tot_q;
	logic [CW-1:0]        ptr_q;
	logic                 pend_q;
	logic                 cval_q;
	logic                 out_valid_q;

	// payload registers
	logic [AW-1:0]                     waddr_q;
	logic [AW-1:0]                     cidx_q;
	logic [atids_pkg::KIND_W-1:0]      kind_q;
	logic [CW-1:0]                     slot_q;
	logic signed [DW-1:0]              data_q;
	logic [atids_pkg::STAT_W-1:0]      stat_q;
	logic                              found_q;
	logic [IW-1:0]                     fidx_q;
	logic signed [DW-1:0]              min_q;
	logic signed [DW-1:0]              max_q;
	logic [atids_pkg::STAT_W-1:0]      status_q;
	logic                              found_out_q;
	logic [atids_pkg::IDX_W-1:0]       found_index_q;
	logic [atids_pkg::CNT_W-1:0]       entry_count_q;
	logic signed [DW-1:0]              smallest_q;
	logic signed [DW-1:0]              largest_q;
	logic signed [atids_pkg::TOT_W-1:0] total_q;

	// memory port signals
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [DW-1:0]        mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [DW-1:0]        mem_rdata;
	logic signed [DW-1:0] rdata;

	logic [SW-1:0]                slot_ext;
	logic [SW-1:0]                occ_ext;
	logic [atids_pkg::STAT_W-1:0] acc_stat;
	logic                         in_accept;
	logic                         ins_more;
	logic                         walk_more;
	logic                         out_free;
	logic                         is_search;
	logic [CW-1:0]                ptr_dec;
	logic [CW-1:0]                ptr_inc;

	assign rdata     = $signed(mem_rdata);
	assign slot_ext  = SW'(slot);
	assign occ_ext   = SW'(occ_q);
	assign in_accept = in_valid && in_ready;
	assign ins_more  = (ptr_q > slot_q);
	assign walk_more = (ptr_q < occ_q);
	assign out_free  = !out_valid_q || out_ready;
	assign is_search = (kind_q != atids_pkg::KIND_INS) && (kind_q != atids_pkg::KIND_DEL);
	assign ptr_dec   = ptr_q - CW'(1);
	assign ptr_inc   = ptr_q + CW'(1);

	// request checks against the current count
	always_comb begin
		acc_stat = atids_pkg::STAT_OK;
		case (kind)
			atids_pkg::KIND_INS: begin
				if (occ_q == CW'(DEPTH)) begin
					acc_stat = atids_pkg::STAT_FULL;
				end else if (slot_ext > occ_ext) begin
					acc_stat = atids_pkg::STAT_RANGE;
				end
			end
			atids_pkg::KIND_DEL: begin
				if (occ_q == '0) begin
					acc_stat = atids_pkg::STAT_EMPTY;
				end else if (slot_ext >= occ_ext) begin
					acc_stat = atids_pkg::STAT_RANGE;
				end
			end
			default: begin
				if (occ_q == '0) begin
					acc_stat = atids_pkg::STAT_EMPTY;
				end
			end
		endcase
	end

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			atids_pkg::ST_IDLE: begin
				if (in_accept) begin
					if (acc_stat != atids_pkg::STAT_OK) begin
						next_state = atids_pkg::ST_SCAN;
					end else if (kind == atids_pkg::KIND_INS) begin
						next_state = atids_pkg::ST_INS;
					end else if (kind == atids_pkg::KIND_DEL) begin
						next_state = atids_pkg::ST_DEL_RD;
					end else begin
						next_state = atids_pkg::ST_SCAN;
					end
				end
			end
			atids_pkg::ST_INS: begin
				if (!ins_more && !pend_q) begin
					next_state = atids_pkg::ST_SCAN;
				end
			end
			atids_pkg::ST_DEL_RD:  next_state = atids_pkg::ST_DEL_SUB;
			atids_pkg::ST_DEL_SUB: next_state = atids_pkg::ST_DEL;
			atids_pkg::ST_DEL: begin
				if (!walk_more && !pend_q) begin
					next_state = atids_pkg::ST_SCAN;
				end
			end
			atids_pkg::ST_SCAN: begin
				if (!walk_more && !cval_q) begin
					next_state = atids_pkg::ST_DONE;
				end
			end
			atids_pkg::ST_DONE: begin
				if (out_free) begin
					next_state = atids_pkg::ST_IDLE;
				end
			end
			default: next_state = atids_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and memory port
	always_comb begin
		in_ready  = 1'b0;
		mem_raddr = '0;
		mem_we    = pend_q;
		mem_waddr = waddr_q;
		mem_wdata = mem_rdata;
		case (state_q)
			atids_pkg::ST_IDLE: in_ready = 1'b1;
			atids_pkg::ST_INS: begin
				mem_raddr = ptr_dec[AW-1:0];
				// last step drops the new value into its slot
				if (!ins_more && !pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_q[AW-1:0];
					mem_wdata = data_q;
				end
			end
			atids_pkg::ST_DEL_RD: mem_raddr = slot_q[AW-1:0];
			atids_pkg::ST_DEL:    mem_raddr = ptr_q[AW-1:0];
			atids_pkg::ST_SCAN:   mem_raddr = ptr_q[AW-1:0];
			default: mem_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atids_pkg::ST_IDLE;
		end else begin
			state_q <= next_state;
		end
	end

	// control path: count, sum, walk pointer, pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			tot_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			cval_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a taken result clears valid unless a new one loads this cycle
			if (out_valid_q && out_ready && state_q != atids_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				atids_pkg::ST_IDLE: begin
					if (in_accept) begin
						ptr_q  <= (acc_stat == atids_pkg::STAT_OK &&
						           kind == atids_pkg::KIND_INS) ? occ_q : '0;
						pend_q <= 1'b0;
						cval_q <= 1'b0;
					end
				end
				atids_pkg::ST_INS: begin
					if (ins_more) begin
						ptr_q  <= ptr_dec;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							occ_q  <= occ_q + CW'(1);
							tot_q  <= tot_q + {{(TW-DW){data_q[DW-1]}}, data_q};
							ptr_q  <= '0;
							cval_q <= 1'b0;
						end
					end
				end
				atids_pkg::ST_DEL_SUB: begin
					tot_q  <= tot_q - {{(TW-DW){rdata[DW-1]}}, rdata};
					ptr_q  <= slot_q + CW'(1);
					pend_q <= 1'b0;
				end
				atids_pkg::ST_DEL: begin
					if (walk_more) begin
						ptr_q  <= ptr_inc;
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							occ_q  <= occ_q - CW'(1);
							ptr_q  <= '0;
							cval_q <= 1'b0;
						end
					end
				end
				atids_pkg::ST_SCAN: begin
					if (walk_more) begin
						ptr_q  <= ptr_inc;
						cval_q <= 1'b1;
					end else begin
						cval_q <= 1'b0;
					end
				end
				atids_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// data path: request fields, scan results, result register
	always_ff @(posedge clk) begin
		case (state_q)
			atids_pkg::ST_IDLE: begin
				if (in_accept) begin
					kind_q  <= kind;
					slot_q  <= slot_ext[CW-1:0];
					data_q  <= item_data;
					stat_q  <= acc_stat;
					found_q <= 1'b0;
					fidx_q  <= '0;
					min_q   <= '0;
					max_q   <= '0;
				end
			end
			atids_pkg::ST_INS: begin
				if (ins_more) begin
					waddr_q <= ptr_q[AW-1:0];
				end
			end
			atids_pkg::ST_DEL: begin
				if (walk_more) begin
					waddr_q <= ptr_dec[AW-1:0];
				end
			end
			atids_pkg::ST_SCAN: begin
				if (walk_more) begin
					cidx_q <= ptr_q[AW-1:0];
				end
				// compare the entry read last cycle
				if (cval_q) begin
					if (cidx_q == '0) begin
						min_q <= rdata;
						max_q <= rdata;
					end else begin
						if (rdata < min_q) begin
							min_q <= rdata;
						end
						if (rdata > max_q) begin
							max_q <= rdata;
						end
					end
					if (is_search && !found_q && rdata == data_q) begin
						found_q <= 1'b1;
						fidx_q  <= IW'(cidx_q);
					end
				end
			end
			atids_pkg::ST_DONE: begin
				if (out_free) begin
					status_q      <= stat_q;
					found_out_q   <= found_q;
					found_index_q <= fidx_q[atids_pkg::IDX_W-1:0];
					entry_count_q <= occ_ext[atids_pkg::CNT_W-1:0];
					smallest_q    <= min_q;
					largest_q     <= max_q;
					total_q       <= tot_q[atids_pkg::TOT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	atids_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found       = found_out_q;
	assign found_index = found_index_q;
	assign entry_count = entry_count_q;
	assign smallest    = smallest_q;
	assign largest     = largest_q;
	assign total       = total_q;

endmodule

`default_nettype wire

@@ src/atids_chk.sv @@
// Port-level checks for the ordered table block, bound to its top level.
// Depends on atids_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module atids_chk #(
	parameter int DEPTH = 64
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic        [atids_pkg::STAT_W-1:0] status,
	input wire logic                                found,
	input wire logic        [atids_pkg::IDX_W-1:0]  found_index,
	input wire logic        [atids_pkg::CNT_W-1:0]  entry_count,
	input wire logic signed [atids_pkg::DATA_W-1:0] smallest,
	input wire logic signed [atids_pkg::DATA_W-1:0] largest,
	input wire logic signed [atids_pkg::TOT_W-1:0]  total
);

	// in_ready is low in the cycle after a taken request
	`AST_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready right after a request")

	// a stalled result holds
	`AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(total) && $stable(entry_count), "stalled result changed")

	// a hit only comes with ok status
	`AST_SAME(a_found_ok, out_valid && found, status == atids_pkg::STAT_OK, "hit with bad status")

	// a miss reports index zero
	`AST_SAME(a_miss_idx, out_valid && !found, found_index == '0, "miss with nonzero index")

	// min never above max
	`AST_SAME(a_min_max, out_valid, smallest <= largest, "smallest above largest")

endmodule

bind array_table_insert_delete_search_top atids_chk #(
	.DEPTH (DEPTH)
) u_atids_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found       (found),
	.found_index (found_index),
	.entry_count (entry_count),
	.smallest    (smallest),
	.largest     (largest),
	.total       (total)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the ordered table block (insert, delete, search).
// Depends on atids_pkg and array_table_insert_delete_search_top; a scoreboard
// class predicts each result from its own copy of the table.
`default_nettype none

module tb_top;

	localparam int TBL_DEPTH = 64;
	localparam int LIMIT     = 1_500_000;

	// widths and codes taken from the package
	localparam int KIND_W = atids_pkg::KIND_W;
	localparam int SLOT_W = atids_pkg::SLOT_W;
	localparam int DATA_W = atids_pkg::DATA_W;
	localparam int STAT_W = atids_pkg::STAT_W;
	localparam int IDX_W  = atids_pkg::IDX_W;
	localparam int CNT_W  = atids_pkg::CNT_W;
	localparam int TOT_W  = atids_pkg::TOT_W;

	localparam logic [KIND_W-1:0] KIND_INS   = atids_pkg::KIND_INS;
	localparam logic [KIND_W-1:0] KIND_DEL   = atids_pkg::KIND_DEL;
	localparam logic [STAT_W-1:0] STAT_OK    = atids_pkg::STAT_OK;
	localparam logic [STAT_W-1:0] STAT_FULL  = atids_pkg::STAT_FULL;
	localparam logic [STAT_W-1:0] STAT_RANGE = atids_pkg::STAT_RANGE;
	localparam logic [STAT_W-1:0] STAT_EMPTY = atids_pkg::STAT_EMPTY;

	// kind codes for a search; the package names only insert and delete
	localparam logic [KIND_W-1:0] KIND_SRCH     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SRCH_ALT = 2'd3;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED
	} op_mix_t;

	typedef struct packed {
		logic        [STAT_W-1:0] status;
		logic                     found;
		logic        [IDX_W-1:0]  found_index;
		logic        [CNT_W-1:0]  entry_count;
		logic signed [DATA_W-1:0] smallest;
		logic signed [DATA_W-1:0] largest;
		logic signed [TOT_W-1:0]  total;
	} table_result_t;

	// Shadow table plus the queue of results still owed by the block
	class table_checker;
		logic signed [DATA_W-1:0] vals [TBL_DEPTH];
		int                       count;
		longint                   sum;
		table_result_t            awaited [$];
		int                       errors;
		int                       checked;
		int                       peak_count;
		int                       hits;
		int                       status_seen [4];

		function new();
			count      = 0;
			sum        = 0;
			errors     = 0;
			checked    = 0;
			peak_count = 0;
			hits       = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// apply one accepted request to the shadow table, queue its result
		function void note_request(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
				logic signed [DATA_W-1:0] d);
			table_result_t r;
			int            i;
			r = '0;
			r.status = STAT_OK;
			if (k == KIND_INS) begin
				if (count >= TBL_DEPTH) begin
					r.status = STAT_FULL;
				end else if (int'(s) > count) begin
					r.status = STAT_RANGE;
				end else begin
					for (i = count; i > int'(s); i--) vals[i] = vals[i-1];
					vals[s] = d;
					count++;
					sum += longint'(d);
				end
			end else if (k == KIND_DEL) begin
				if (count == 0) begin
					r.status = STAT_EMPTY;
				end else if (int'(s) >= count) begin
					r.status = STAT_RANGE;
				end else begin
					sum -= longint'(vals[s]);
					for (i = int'(s); i + 1 < count; i++) vals[i] = vals[i+1];
					count--;
				end
			end else begin
				if (count == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					for (i = 0; i < count; i++) begin
						if (vals[i] == d) begin
							r.found       = 1'b1;
							r.found_index = IDX_W'(i);
							break;
						end
					end
				end
			end
			// min and max over the live entries
			if (count > 0) begin
				r.smallest = vals[0];
				r.largest  = vals[0];
				for (i = 1; i < count; i++) begin
					if (vals[i] < r.smallest) r.smallest = vals[i];
					if (vals[i] > r.largest) r.largest = vals[i];
				end
			end
			r.entry_count = CNT_W'(count);
			r.total       = TOT_W'(sum);
			if (count > peak_count) peak_count = count;
			status_seen[r.status]++;
			if (r.found) hits++;
			awaited.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
			end
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, actual status %0d",
					$time, got.status);
				return;
			end
			want = awaited.pop_front();
			checked++;
			compare_field("status", want.status, got.status);
			compare_field("found", want.found, got.found);
			compare_field("found_index", want.found_index, got.found_index);
			compare_field("entry_count", want.entry_count, got.entry_count);
			compare_field("smallest", want.smallest, got.smallest);
			compare_field("largest", want.largest, got.largest);
			compare_field("total", want.total, got.total);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic        [KIND_W-1:0] kind;
	logic        [SLOT_W-1:0] slot;
	logic signed [DATA_W-1:0] item_data;
	logic                     out_valid;
	logic                     out_ready;
	logic        [STAT_W-1:0] status;
	logic                     found;
	logic        [IDX_W-1:0]  found_index;
	logic        [CNT_W-1:0]  entry_count;
	logic signed [DATA_W-1:0] smallest;
	logic signed [DATA_W-1:0] largest;
	logic signed [TOT_W-1:0]  total;

	table_checker sb = new();
	int           sender_idle_pct = 0;
	int           recv_stall_pct  = 0;
	int           sent            = 0;
	int           cycle_count     = 0;

	array_table_insert_delete_search_top #(
		.DEPTH(TBL_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.slot       (slot),
		.item_data  (item_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found      (found),
		.found_index(found_index),
		.entry_count(entry_count),
		.smallest   (smallest),
		.largest    (largest),
		.total      (total)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// watchdog
	initial begin
		wait (cycle_count >= LIMIT);
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("Verification failed");
		$finish;
	end

	// result side: check on handshake, then pick next ready
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result('{status, found, found_index, entry_count,
					smallest, largest, total});
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// one request: optional idle gap, then hold valid until taken.
	// valid stays high on return so back-to-back requests need no toggle.
	task automatic send_request(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
			input logic signed [DATA_W-1:0] d);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		slot      <= s;
		item_data <= d;
		do @(posedge clk); while (!in_ready);
		sb.note_request(k, s, d);
		sent++;
	endtask

	// hold off until every queued result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input int theme);
		int roll;
		roll = $urandom_range(0, 99);
		if (theme == 1 && roll < 75) return 32'sh7fffffff;
		if (theme == 2 && roll < 75) return 32'sh80000000;
		if (theme == 3 && roll < 75) return DATA_W'($urandom_range(0, 6)) - 32'd3;
		case ($urandom_range(0, 9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return 32'sd0;
			3:       return -32'sd1;
			4, 5:    return DATA_W'($urandom_range(0, 6)) - 32'd3;
			default: return $urandom();
		endcase
	endfunction

	// random traffic in blocks that fill, drain or churn the table
	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
		int                       done_items;
		int                       block_len;
		int                       theme;
		int                       roll;
		int                       cnt;
		op_mix_t                  mix;
		logic        [KIND_W-1:0] k;
		logic        [SLOT_W-1:0] s;
		logic signed [DATA_W-1:0] d;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		done_items      = 0;
		while (done_items < n_items) begin
			block_len = $urandom_range(60, 140);
			if (block_len > n_items - done_items) block_len = n_items - done_items;
			mix       = op_mix_t'($urandom_range(0, 2));
			theme     = $urandom_range(0, 3);
			repeat (block_len) begin
				cnt = sb.count;
				if ($urandom_range(0, 99) < 5) begin
					// noise: any kind, a slot from 0 to 64, any data
					k = KIND_W'($urandom_range(0, 3));
					s = SLOT_W'($urandom_range(0, 64));
					d = $urandom();
				end else begin
					roll = $urandom_range(0, 99);
					case (mix)
						MIX_FILL:  k = roll < 70 ? KIND_INS : (roll < 80 ? KIND_DEL : KIND_SRCH);
						MIX_DRAIN: k = roll < 10 ? KIND_INS : (roll < 80 ? KIND_DEL : KIND_SRCH);
						default:   k = roll < 35 ? KIND_INS : (roll < 70 ? KIND_DEL : KIND_SRCH);
					endcase
					roll = $urandom_range(0, 9);
					if (k == KIND_INS) begin
						// front, back, past the end, or anywhere inside
						if (roll == 0) s = '0;
						else if (roll == 1) s = SLOT_W'(cnt);
						else if (roll == 2) s = SLOT_W'(cnt < 64 ? $urandom_range(cnt + 1, 64) : 64);
						else s = SLOT_W'($urandom_range(0, cnt));
						d = pick_value(theme);
					end else if (k == KIND_DEL) begin
						if (roll == 0) s = '0;
						else if (roll == 1) s = SLOT_W'(cnt > 0 ? cnt - 1 : 0);
						else if (roll == 2) s = SLOT_W'($urandom_range(cnt, 64));
						else s = SLOT_W'(cnt > 0 ? $urandom_range(0, cnt - 1) : 0);
						d = $urandom();
					end else begin
						// mostly keys that are present, so hits and duplicates show up
						if ($urandom_range(0, 99) < 15) k = KIND_SRCH_ALT;
						s = SLOT_W'($urandom_range(0, 64));
						if (cnt > 0 && roll < 6) d = sb.vals[$urandom_range(0, cnt - 1)];
						else d = pick_value(theme);
					end
				end
				send_request(k, s, d);
				done_items++;
			end
		end
		drain_results();
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		kind      <= KIND_INS;
		slot      <= '0;
		item_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table cases, range errors, front/middle/back, duplicates
		send_request(KIND_DEL, 7'd0, 32'sd0);
		send_request(KIND_SRCH, 7'd0, 32'sd5);
		send_request(KIND_SRCH_ALT, 7'd64, 32'sd0);
		send_request(KIND_INS, 7'd1, 32'sd9);
		send_request(KIND_INS, 7'd64, 32'sd9);
		send_request(KIND_INS, 7'd0, 32'sh7fffffff);
		send_request(KIND_INS, 7'd1, 32'sh80000000);
		send_request(KIND_INS, 7'd0, -32'sd1);
		send_request(KIND_INS, 7'd2, 32'sd0);
		send_request(KIND_INS, 7'd4, 32'sh7fffffff);
		send_request(KIND_SRCH, 7'd127, 32'sh7fffffff);
		send_request(KIND_SRCH, 7'd0, 32'sd12345);
		send_request(KIND_SRCH_ALT, 7'd0, 32'sh80000000);
		send_request(KIND_DEL, 7'd5, 32'sd0);
		send_request(KIND_DEL, 7'd64, 32'sd0);
		send_request(KIND_DEL, 7'd2, 32'sh55555555);
		send_request(KIND_DEL, 7'd3, 32'shaaaaaaaa);
		send_request(KIND_DEL, 7'd0, 32'sd0);
		send_request(KIND_SRCH, 7'd0, -32'sd1);
		send_request(KIND_DEL, 7'd0, 32'sd0);
		send_request(KIND_DEL, 7'd0, 32'sd0);
		send_request(KIND_SRCH, 7'd0, 32'sd0);
		send_request(KIND_INS, 7'd0, 32'sh55555555);
		send_request(KIND_SRCH, 7'd0, 32'sh55555555);
		drain_results();

		// random phases under different back-pressure patterns
		run_phase(445, 0, 0);
		run_phase(445, 56, 0);
		run_phase(445, 0, 56);
		run_phase(445, 29, 29);

		// stragglers: allow a full worst-case request time
		repeat (2 * TBL_DEPTH + 20) @(posedge clk);

		$display("Ran %0d requests, %0d results checked, peak occupancy %0d of %0d.",
			sent, sb.checked, sb.peak_count, TBL_DEPTH);
		$display("Statuses: ok %0d, full %0d, out of range %0d, empty %0d; search hits %0d.",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_FULL],
			sb.status_seen[STAT_RANGE], sb.status_seen[STAT_EMPTY], sb.hits);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0t: %0d mismatches, %0d results never arrived", $time, sb.errors,
				sb.pending());
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+src
src/atids_pkg.sv
src/atids_mem.sv
src/array_table_insert_delete_search_top.sv
src/atids_chk.sv
verif/tb_top.sv
